/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define CPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define CPD_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* design/cpd_pkg.sv */
package cpd_pkg;

  // stream and register widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned OutUserW = 2;
  localparam int unsigned PixW     = 16;
  localparam int unsigned PosW     = 16;
  localparam int unsigned VelW     = PosW + 1;
  localparam int unsigned GmvW     = PosW + 2;
  localparam int unsigned PulseW   = 11;
  localparam int unsigned GainW    = 16;
  localparam int unsigned TrimW    = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // normalization divider sizes, dividends stay below 2^26
  localparam int unsigned NumW     = 33;
  localparam int unsigned DivW     = 26;
  localparam int unsigned RecipW   = 27;
  localparam int unsigned DivShift = 36;
  localparam int unsigned QuotW    = DivW + RecipW - DivShift;
  localparam int unsigned DvsW     = 11;

  // shared multiplier sizes
  localparam int unsigned MulAW = 28;
  localparam int unsigned MulBW = 21;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned AccW  = 40;

  // frame header and normalization
  localparam logic [ByteW-1:0]      SyncFirst  = 8'hAA;
  localparam logic [ByteW-1:0]      SyncSecond = 8'h55;
  localparam logic signed [VelW-1:0] CenterX   = 17'sd374;
  localparam logic signed [VelW-1:0] CenterY   = 17'sd254;
  localparam logic signed [VelW-1:0] DeltaLim  = 17'sd2000;
  localparam int unsigned           ShiftX     = 15;
  localparam int unsigned           ShiftY     = 14;
  localparam logic signed [NumW-1:0] HalfDenX  = 33'sd777;
  localparam logic signed [NumW-1:0] HalfDenY  = 33'sd413;
  localparam logic [DvsW-1:0]       DenX       = 11'd1554;
  localparam logic [DvsW-1:0]       DenY       = 11'd826;
  // rounded-up 2^36 / den
  localparam logic [RecipW-1:0]     RecipX     = 27'd44221028;
  localparam logic [RecipW-1:0]     RecipY     = 27'd83195493;

  // control loop constants, angles in Q.20 degrees
  localparam logic signed [VelW-1:0] VelBand   = 17'sd410;
  localparam logic signed [PosW-1:0] PosBand   = 16'sd820;
  localparam logic signed [AccW-1:0] AngleBase = 40'sd94371840;
  localparam logic signed [AccW-1:0] AngleMin  = 40'sd68157440;
  localparam logic signed [AccW-1:0] AngleMax  = 40'sd120586240;
  localparam int unsigned            TrimShift = 12;
  localparam logic signed [MulBW-1:0] PulseScale = 21'sd1111;
  localparam logic signed [MulBW-1:0] Recip25    = 21'sd671089;
  localparam int unsigned            ScaleShift = 22;
  localparam int unsigned            ScaledW    = 19;
  localparam int unsigned            RecipShift = 24;
  localparam int unsigned            GoalShift  = 8;
  localparam logic [PulseW-1:0]      PulseBase  = 11'd500;
  localparam logic [PulseW-1:0]      PulseReset = 11'd1500;
  localparam logic signed [AccW-1:0] Sat16Max   = 40'sd32767;
  localparam logic signed [AccW-1:0] Sat16Min   = -40'sd32768;

  // register reset values
  localparam logic [GainW-1:0]        PosGainPReset = 16'd128;
  localparam logic [GainW-1:0]        PosGainDReset = 16'd1536;
  localparam logic [GainW-1:0]        VelGainPReset = 16'd192;
  localparam logic [GainW-1:0]        VelGainDReset = 16'd1024;
  localparam logic signed [TrimW-1:0] TrimXReset    = 13'sd768;
  localparam logic signed [TrimW-1:0] TrimYReset    = -13'sd768;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgPosGainP = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPosGainD = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgVelGainP = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgVelGainD = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTrimX    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTrimY    = 3'd5;

  typedef enum logic [4:0] {
    StIdle,
    StCheck,
    StDivStart,
    StDivWait,
    StInMul1,
    StInMul2,
    StInAcc,
    StInTriple,
    StInAngle,
    StPwMul1,
    StPwMul2,
    StPwSet,
    StOutMul1,
    StOutMul2,
    StOutSet,
    StResult
  } state_e;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DivW-1:0]   dividend;
    logic [RecipW-1:0] recip;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

endpackage

/* design/cascaded_pd_two_axis_servo.sv */
// tick: inner loop on each axis, then the position loop as well when it runs
// frame: normalizes both axes, or skips to the result if rejected; ready again next cycle
// one request at a time; a held result stalls the sequencer; loop products share one
// 28x21 multiplier and the normalization uses a reciprocal multiply in its own unit
// reset (async, active low) restores the default gains and trims, clears position and
// velocity state and sets both held pulses to 1500
module cascaded_pd_two_axis_servo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sync_first, sync_second, xpix_high, xpix_low, ypix_high, ypix_low, sum_byte
  input  logic [cpd_pkg::InDataW-1:0]    s_axis_tdata,
  // mode
  input  logic [cpd_pkg::InUserW-1:0]    s_axis_tuser,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // norm_x, norm_y, pulse_x, pulse_y, zero fill
  output logic [cpd_pkg::OutDataW-1:0]   m_axis_tdata,
  // frame_accepted, outer_ran
  output logic [cpd_pkg::OutUserW-1:0]   m_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we_i,
  input  logic [cpd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cpd_pkg::CfgDataW-1:0]   cfg_data_i
);
  import cpd_pkg::*;

  // configuration
  logic [GainW-1:0]        pos_gain_p_q, pos_gain_d_q, vel_gain_p_q, vel_gain_d_q;
  logic signed [TrimW-1:0] trim_x_q, trim_y_q;

  // loop state
  logic signed [PosW-1:0] pos_x_q, pos_y_q, last_pos_x_q, last_pos_y_q;
  logic signed [PosW-1:0] last_err_x_q, last_err_y_q, goal_vel_x_q, goal_vel_y_q;
  logic                   tick_phase_q;
  logic [PulseW-1:0]      held_pulse_x_q, held_pulse_y_q;

  // sequencer and working registers
  state_e                 state_q, state_d;
  logic [InDataW-1:0]     item_q;
  logic                   mode_q;
  logic                   ax_q;
  logic                   accepted_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q;

  // output register
  logic                   out_valid_q;
  logic [OutDataW-1:0]    out_data_q;
  logic [OutUserW-1:0]    out_user_q;

  logic                   in_acc;
  logic                   out_load;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_gain_p_q <= PosGainPReset;
      pos_gain_d_q <= PosGainDReset;
      vel_gain_p_q <= VelGainPReset;
      vel_gain_d_q <= VelGainDReset;
      trim_x_q     <= TrimXReset;
      trim_y_q     <= TrimYReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPosGainP: pos_gain_p_q <= cfg_data_i;
        CfgPosGainD: pos_gain_d_q <= cfg_data_i;
        CfgVelGainP: vel_gain_p_q <= cfg_data_i;
        CfgVelGainD: vel_gain_d_q <= cfg_data_i;
        CfgTrimX:    trim_x_q     <= cfg_data_i[TrimW-1:0];
        CfgTrimY:    trim_y_q     <= cfg_data_i[TrimW-1:0];
        default:     ;
      endcase
    end
  end

  // frame fields
  logic [ByteW-1:0]        sync_first, sync_second, sum_byte, sum_calc;
  logic signed [PixW-1:0]  raw_x, raw_y;
  logic signed [VelW-1:0]  dx, dy, dx_c, dy_c;
  logic signed [NumW-1:0]  num_x, num_y, num_cur, den_s, mag;
  logic [DvsW-1:0]         den_cur;
  logic                    frame_ok;
  logic                    num_neg;
  logic [QuotW-1:0]        quot;
  logic [VelW-1:0]         quot_low;
  logic signed [PosW-1:0]  norm_res;

  assign sync_first  = item_q[7:0];
  assign sync_second = item_q[15:8];
  assign raw_x       = {item_q[23:16], item_q[31:24]};
  assign raw_y       = {item_q[39:32], item_q[47:40]};
  assign sum_byte    = item_q[55:48];
  assign sum_calc    = SyncFirst + SyncSecond + item_q[23:16] + item_q[31:24]
                     + item_q[39:32] + item_q[47:40];
  assign frame_ok    = (sync_first == SyncFirst) && (sync_second == SyncSecond)
                     && (sum_calc == sum_byte);

  // offsets well past the saturation point are pulled in so the dividend stays small
  assign dx   = VelW'(raw_x) - CenterX;
  assign dy   = VelW'(raw_y) - CenterY;
  assign dx_c = (dx > DeltaLim) ? DeltaLim : (dx < -DeltaLim) ? -DeltaLim : dx;
  assign dy_c = (dy > DeltaLim) ? DeltaLim : (dy < -DeltaLim) ? -DeltaLim : dy;

  // rounded numerator 2*(p - c)*k + den, divided by 2*den
  assign num_x   = (NumW'(dx_c) <<< ShiftX) + HalfDenX;
  assign num_y   = (NumW'(dy_c) <<< ShiftY) + HalfDenY;
  assign num_cur = ax_q ? num_y : num_x;
  assign den_cur = ax_q ? DenY : DenX;
  assign den_s   = NumW'($signed({1'b0, den_cur}));
  assign num_neg = num_cur[NumW-1];
  // floor of a negative quotient as minus the ceiling of its magnitude
  assign mag     = num_neg ? (den_s - NumW'(1) - num_cur) : num_cur;

  assign div_req.start    = (state_q == StDivStart);
  assign div_req.dividend = mag[DivW-1:0];
  assign div_req.recip    = ax_q ? RecipY : RecipX;

  cpd_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // saturate the signed quotient to 16 bits
  assign quot     = div_rsp.quot;
  assign quot_low = quot[VelW-1:0];
  always_comb begin
    if (!num_neg) begin
      norm_res = (quot > QuotW'(32767)) ? 16'sh7FFF : quot[PosW-1:0];
    end else begin
      norm_res = (quot > QuotW'(32768)) ? 16'sh8000 : PosW'(VelW'(0) - quot_low);
    end
  end

  // per-axis views of the loop state
  logic signed [PosW-1:0]  cur_pos, cur_last, cur_goal, cur_lerr, cur_err;
  logic signed [TrimW-1:0] cur_trim;
  logic signed [VelW-1:0]  vel_raw, vel_db, err_diff;
  logic signed [GmvW-1:0]  goal_minus_v;

  assign cur_pos  = ax_q ? pos_y_q      : pos_x_q;
  assign cur_last = ax_q ? last_pos_y_q : last_pos_x_q;
  assign cur_goal = ax_q ? goal_vel_y_q : goal_vel_x_q;
  assign cur_lerr = ax_q ? last_err_y_q : last_err_x_q;
  assign cur_trim = ax_q ? trim_y_q     : trim_x_q;

  // inner loop speed with deadband
  assign vel_raw      = VelW'(cur_pos) - VelW'(cur_last);
  assign vel_db       = (vel_raw > -VelBand && vel_raw < VelBand) ? '0 : vel_raw;
  assign goal_minus_v = GmvW'(cur_goal) - GmvW'(vel_db);

  // outer loop error with deadband
  assign cur_err  = (cur_pos > -PosBand && cur_pos < PosBand) ? '0 : cur_pos;
  assign err_diff = VelW'(cur_err) - VelW'(cur_lerr);

  // shared multiplier operand select
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StInMul1: begin
        mul_a = MulAW'(goal_minus_v);
        mul_b = MulBW'($signed({1'b0, vel_gain_p_q}));
      end
      StInMul2: begin
        mul_a = MulAW'(vel_db);
        mul_b = MulBW'($signed({1'b0, vel_gain_d_q}));
      end
      StPwMul1: begin
        mul_a = acc_q[MulAW-1:0];
        mul_b = PulseScale;
      end
      StPwMul2: begin
        mul_a = MulAW'($signed({1'b0, prod_q[ScaleShift+ScaledW-1:ScaleShift]}));
        mul_b = Recip25;
      end
      StOutMul1: begin
        mul_a = MulAW'(cur_err);
        mul_b = MulBW'($signed({1'b0, pos_gain_p_q}));
      end
      StOutMul2: begin
        mul_a = MulAW'(err_diff);
        mul_b = MulBW'($signed({1'b0, pos_gain_d_q}));
      end
      default: ;
    endcase
  end

  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  // angle, clamp, pulse and outer goal arithmetic
  logic signed [AccW-1:0]  prod_lo, ang_raw, ang_clamp, goal_sum, goal_shift;
  logic signed [PosW-1:0]  goal_sat;
  logic [PulseW-1:0]       pulse_new;

  assign prod_lo  = prod_q[AccW-1:0];
  assign ang_raw  = AngleBase + (AccW'(cur_trim) <<< TrimShift) + (ax_q ? acc_q : -acc_q);
  assign ang_clamp = (ang_raw < AngleMin) ? AngleMin :
                     (ang_raw > AngleMax) ? AngleMax : ang_raw;
  assign pulse_new = PulseBase + prod_q[RecipShift+PulseW-1:RecipShift];
  assign goal_sum  = acc_q + prod_lo;
  assign goal_shift = goal_sum >>> GoalShift;
  assign goal_sat  = (goal_shift > Sat16Max) ? 16'sh7FFF :
                     (goal_shift < Sat16Min) ? 16'sh8000 : goal_shift[PosW-1:0];

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = s_axis_tuser[0] ? StInMul1 : StCheck;
        end
      end
      StCheck:    state_d = frame_ok ? StDivStart : StResult;
      StDivStart: state_d = StDivWait;
      StDivWait: begin
        if (div_rsp.done) begin
          state_d = ax_q ? StResult : StDivStart;
        end
      end
      StInMul1:   state_d = StInMul2;
      StInMul2:   state_d = StInAcc;
      StInAcc:    state_d = StInTriple;
      StInTriple: state_d = StInAngle;
      StInAngle:  state_d = StPwMul1;
      StPwMul1:   state_d = StPwMul2;
      StPwMul2:   state_d = StPwSet;
      StPwSet: begin
        if (!ax_q) begin
          state_d = StInMul1;
        end else if (tick_phase_q) begin
          state_d = StOutMul1;
        end else begin
          state_d = StResult;
        end
      end
      StOutMul1:  state_d = StOutMul2;
      StOutMul2:  state_d = StOutSet;
      StOutSet:   state_d = ax_q ? StResult : StOutMul1;
      StResult: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default:    state_d = StIdle;
    endcase
  end

  // loop state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q        <= '0;
      pos_y_q        <= '0;
      last_pos_x_q   <= '0;
      last_pos_y_q   <= '0;
      last_err_x_q   <= '0;
      last_err_y_q   <= '0;
      goal_vel_x_q   <= '0;
      goal_vel_y_q   <= '0;
      tick_phase_q   <= 1'b0;
      held_pulse_x_q <= PulseReset;
      held_pulse_y_q <= PulseReset;
    end else begin
      if (state_q == StDivWait && div_rsp.done) begin
        if (ax_q) begin
          pos_y_q <= norm_res;
        end else begin
          pos_x_q <= norm_res;
        end
      end
      if (state_q == StPwSet) begin
        if (ax_q) begin
          held_pulse_y_q <= pulse_new;
        end else begin
          held_pulse_x_q <= pulse_new;
        end
      end
      if (state_q == StOutSet) begin
        if (ax_q) begin
          goal_vel_y_q <= goal_sat;
          last_err_y_q <= cur_err;
        end else begin
          goal_vel_x_q <= goal_sat;
          last_err_x_q <= cur_err;
        end
      end
      if (out_load && mode_q) begin
        last_pos_x_q <= pos_x_q;
        last_pos_y_q <= pos_y_q;
        tick_phase_q <= ~tick_phase_q;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (in_acc) begin
      item_q     <= s_axis_tdata;
      mode_q     <= s_axis_tuser[0];
      ax_q       <= 1'b0;
      accepted_q <= 1'b0;
    end
    case (state_q)
      StCheck:    accepted_q <= frame_ok;
      StDivWait: begin
        if (div_rsp.done) begin
          ax_q <= 1'b1;
        end
      end
      StInMul2:   acc_q <= prod_lo;
      StInAcc:    acc_q <= acc_q + prod_lo;
      StInTriple: acc_q <= acc_q + (acc_q <<< 1);
      StInAngle:  acc_q <= ang_clamp;
      StPwSet:    ax_q  <= ~ax_q;
      StOutMul2:  acc_q <= prod_lo;
      StOutSet:   ax_q  <= 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {2'b00, held_pulse_y_q, held_pulse_x_q, pos_y_q, pos_x_q};
      out_user_q <= {mode_q & tick_phase_q, accepted_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

/* design/cpd_divider.sv */
module cpd_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpd_pkg::div_req_t req_i,
  output cpd_pkg::div_rsp_t rsp_o
);
  import cpd_pkg::*;

  localparam int unsigned ProdDW = DivW + RecipW;

  logic              mul_go_q;
  logic              done_q;
  logic [DivW-1:0]   num_q;
  logic [RecipW-1:0] recip_q;
  logic [QuotW-1:0]  quot_q;
  logic [ProdDW-1:0] prod;

  // quotient as the top bits of dividend times the rounded-up reciprocal
  assign prod = ProdDW'(num_q) * ProdDW'(recip_q);

  // control: operands taken, then quotient and done registered together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_go_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      mul_go_q <= req_i.start;
      done_q   <= mul_go_q;
    end
  end

  // operand and quotient registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q   <= req_i.dividend;
      recip_q <= req_i.recip;
    end
    if (mul_go_q) begin
      quot_q <= prod[ProdDW-1:DivShift];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

/* design/cpd_checker.sv */
`include "assert_macros.svh"

module cpd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [cpd_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [cpd_pkg::OutUserW-1:0]  m_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready
);
  import cpd_pkg::*;

  localparam logic [PulseW-1:0] PulseLow  = 11'd1222;
  localparam logic [PulseW-1:0] PulseHigh = 11'd1777;

  logic                         in_acc;
  logic                         out_stall;
  logic [OutUserW+OutDataW-1:0] out_word;
  logic [PulseW-1:0]            pulse_x, pulse_y;
  logic                         pulse_x_ok, pulse_y_ok;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_word   = {m_axis_tuser, m_axis_tdata};
  assign pulse_x    = m_axis_tdata[42:32];
  assign pulse_y    = m_axis_tdata[53:43];
  assign pulse_x_ok = (pulse_x >= PulseLow) && (pulse_x <= PulseHigh);
  assign pulse_y_ok = (pulse_y >= PulseLow) && (pulse_y <= PulseHigh);

  // a stalled result holds
  `CPD_ASSERT(a_out_hold, out_stall |=> (m_axis_tvalid && $stable(out_word)), "stalled result changed")

  // one request at a time: busy right after taking one
  `CPD_ASSERT(a_busy_after_req, in_acc |=> !s_axis_tready, "request taken while busy")

  // clamped angles keep both pulses in range
  `CPD_ASSERT(a_pulse_range, m_axis_tvalid |-> (pulse_x_ok && pulse_y_ok), "pulse out of range")

  // a result is either a frame result or a tick result
  `CPD_ASSERT_NEVER(a_flags_excl, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1], "frame and position loop flags together")

endmodule

bind cascaded_pd_two_axis_servo cpd_checker u_cpd_checker (.*);
